/* rtl/loss_based_bitrate_controller_top_macros.svh */
// ----------------------------------------------------------------------------
// bitrate controller assertion macros
// shared concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef LOSS_BASED_BITRATE_CONTROLLER_TOP_MACROS_SVH
`define LOSS_BASED_BITRATE_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LBC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LBC_ASSERT_IMPL(label, ante, cons, msg)
`define LBC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// types, register map and constants of the loss based bitrate controller
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int RATE_W   = 32;
    localparam int Q16_W    = 16;
    localparam int MS_W     = 10;
    localparam int LBC_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;
    localparam int FRAC_BITS  = 14;

    // request kinds
    localparam logic [1:0] REQ_REMB     = 2'd0;
    localparam logic [1:0] REQ_LOSS     = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;
    localparam logic [1:0] REQ_OVERRIDE = 2'd3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_START = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_THR   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DEC   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INC   = 3'd5;

    // reset values
    localparam logic [RATE_W-1:0] RST_START = 32'd300000;
    localparam logic [RATE_W-1:0] RST_MIN   = 32'd30000;
    localparam logic [RATE_W-1:0] RST_MAX   = 32'd2500000;
    localparam logic [Q16_W-1:0]  RST_THR   = 16'd6554;
    localparam logic [Q16_W-1:0]  RST_DEC   = 16'd13926;
    localparam logic [Q16_W-1:0]  RST_INC   = 16'd17695;

    // overuse ends below 0.005 in Q0.16
    localparam logic [Q16_W-1:0] LOSS_CLEAR = 16'd328;

    // floor(x / 50) = (x * RECIP_50) >> RECIP_SHIFT for any 32-bit x
    localparam logic [RATE_W-1:0] RECIP_50    = 32'h51EB851F;
    localparam int                RECIP_SHIFT = 36;

    typedef struct packed {
        logic              load_start;
        logic [RATE_W-1:0] start_rate;
        logic [RATE_W-1:0] min_rate;
        logic [RATE_W-1:0] max_rate;
        logic [Q16_W-1:0]  loss_thr;
        logic [Q16_W-1:0]  dec_factor;
        logic [Q16_W-1:0]  inc_factor;
    } cfg_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              overuse;
        logic              changed;
    } upd_t;

    // lower bound is tested first
    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W+1:0] v,
                                                    input logic [RATE_W-1:0] lo,
                                                    input logic [RATE_W-1:0] hi);
        logic [RATE_W-1:0] res;
        if (v < {2'b00, lo}) begin
            res = lo;
        end else if (v > {2'b00, hi}) begin
            res = hi;
        end else begin
            res = v[RATE_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/lbc_ifs.sv */
// ----------------------------------------------------------------------------
// lbc request and response channels
// valid/ready channels carrying the controller requests and results
// ----------------------------------------------------------------------------
interface lbc_req_if
    import lbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [RATE_W-1:0] bitrate_value;
    logic [Q16_W-1:0]  loss_value;

    modport source (output valid, req_type, bitrate_value, loss_value, input ready);
    modport sink   (input valid, req_type, bitrate_value, loss_value, output ready);
endinterface

interface lbc_rsp_if
    import lbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] estimated_bitrate;
    logic [RATE_W-1:0] cap_bitrate;
    logic [Q16_W-1:0]  loss_level;
    logic              overuse_active;
    logic              underuse_active;
    logic              bitrate_changed;

    modport source (output valid, estimated_bitrate, cap_bitrate, loss_level,
                    overuse_active, underuse_active, bitrate_changed, input ready);
    modport sink   (input valid, estimated_bitrate, cap_bitrate, loss_level,
                    overuse_active, underuse_active, bitrate_changed, output ready);
endinterface

/* rtl/lbc_regs.sv */
// ----------------------------------------------------------------------------
// lbc_regs
// apb configuration registers of the bitrate controller
// ----------------------------------------------------------------------------
module lbc_regs
    import lbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [LBC_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output cfg_t                  cfg
);

    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;
    logic [RATE_W-1:0]    start_reg;
    logic [RATE_W-1:0]    min_reg;
    logic [RATE_W-1:0]    max_reg;
    logic [Q16_W-1:0]     thr_reg;
    logic [Q16_W-1:0]     dec_reg;
    logic [Q16_W-1:0]     inc_reg;

    assign idx   = paddr[LBC_ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= RST_START;
            min_reg   <= RST_MIN;
            max_reg   <= RST_MAX;
            thr_reg   <= RST_THR;
            dec_reg   <= RST_DEC;
            inc_reg   <= RST_INC;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_START: start_reg <= pwdata;
                REG_MIN:   min_reg   <= pwdata;
                REG_MAX:   max_reg   <= pwdata;
                REG_THR:   thr_reg   <= pwdata[Q16_W-1:0];
                REG_DEC:   dec_reg   <= pwdata[Q16_W-1:0];
                REG_INC:   inc_reg   <= pwdata[Q16_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START: prdata = start_reg;
            REG_MIN:   prdata = min_reg;
            REG_MAX:   prdata = max_reg;
            REG_THR:   prdata = {16'd0, thr_reg};
            REG_DEC:   prdata = {16'd0, dec_reg};
            REG_INC:   prdata = {16'd0, inc_reg};
            default:   prdata = '0;
        endcase
    end

    // start write also reloads current and target rate in the core
    assign cfg.load_start = wr_en && (idx == REG_START);
    assign cfg.start_rate = pwdata;
    assign cfg.min_rate   = min_reg;
    assign cfg.max_rate   = max_reg;
    assign cfg.loss_thr   = thr_reg;
    assign cfg.dec_factor = dec_reg;
    assign cfg.inc_factor = inc_reg;

endmodule

/* rtl/lbc_rate_calc.sv */
// ----------------------------------------------------------------------------
// lbc_rate_calc
// one rate update: scale, clamp to min/max, cap by target
// ----------------------------------------------------------------------------
module lbc_rate_calc
    import lbc_pkg::*;
(
    input  cfg_t              cfg,
    input  logic [RATE_W-1:0] current,
    input  logic [RATE_W-1:0] target,
    input  logic [Q16_W-1:0]  loss,
    input  logic              overuse,
    output upd_t              upd
);

    logic                      high_loss;
    logic [Q16_W-1:0]          factor;
    logic [RATE_W+Q16_W-1:0]   prod_f;
    logic [RATE_W+1:0]         scaled;
    logic [2*RATE_W-1:0]       prod_q;
    logic [RATE_W:0]           recov;
    logic [RATE_W+1:0]         cand;
    logic [RATE_W-1:0]         clamped;
    logic [RATE_W-1:0]         capped;

    assign high_loss = loss > cfg.loss_thr;
    assign factor    = high_loss ? cfg.dec_factor : cfg.inc_factor;

    // Q2.14 product, truncated
    assign prod_f = {{Q16_W{1'b0}}, current} * {{RATE_W{1'b0}}, factor};
    assign scaled = prod_f[RATE_W+Q16_W-1:FRAC_BITS];

    // recovery: rate * 51 / 50 equals rate + rate / 50
    assign prod_q = {{RATE_W{1'b0}}, current} * {{RATE_W{1'b0}}, RECIP_50};
    assign recov  = {1'b0, current}
                  + {{(RECIP_SHIFT-RATE_W+1){1'b0}}, prod_q[2*RATE_W-1:RECIP_SHIFT]};

    assign cand    = (high_loss || !overuse) ? scaled : {1'b0, recov};
    assign clamped = clamp_rate(cand, cfg.min_rate, cfg.max_rate);
    assign capped  = (clamped > target) ? target : clamped;

    assign upd.rate    = capped;
    assign upd.overuse = high_loss || (overuse && (loss >= LOSS_CLEAR));
    assign upd.changed = capped != current;

endmodule

/* rtl/loss_based_bitrate_controller_top.sv */
// ----------------------------------------------------------------------------
// loss_based_bitrate_controller_top
// loss driven multiplicative bitrate controller with receiver rate cap
//
//   channel  | dir | handshake          | carries
//   ---------+-----+--------------------+---------------------------------
//   req      | in  | valid/ready        | req_type, bitrate_value, loss
//   rsp      | out | valid/ready        | estimate, cap, loss, flags
//   apb      | in  | psel/penable       | six config registers, 4-byte step
//
// one request per cycle; each passes from acceptance to result through
// a request register, then the rate update and the result register
// the update (one 32x16 and one 32x32 multiply, clamp, cap) sets the cycle
// a stalled result holds the request register; req.ready drops only then
// reset loads the register defaults; no clearing pass
// ----------------------------------------------------------------------------
`include "loss_based_bitrate_controller_top_macros.svh"

module loss_based_bitrate_controller_top
    import lbc_pkg::*;
#(
    parameter int unsigned UPDATE_PERIOD_MS = 25
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lbc_req_if.sink               req,
    lbc_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [LBC_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [MS_W-1:0] PERIOD_CNT = MS_W'(UPDATE_PERIOD_MS);

    cfg_t cfg;
    upd_t upd;

    // request register
    logic              stg_valid_reg;
    logic [1:0]        stg_type_reg;
    logic [RATE_W-1:0] stg_rate_reg;
    logic [Q16_W-1:0]  stg_loss_reg;

    // controller state
    logic [RATE_W-1:0] current_reg, current_next;
    logic [RATE_W-1:0] target_reg, target_next;
    logic [Q16_W-1:0]  loss_reg, loss_next;
    logic              overuse_reg, overuse_next;
    logic [MS_W-1:0]   ms_reg, ms_next;

    // result register
    logic              out_valid_reg;
    logic              changed_reg, changed_next;

    logic              adv;
    logic              run_upd;
    logic [MS_W-1:0]   ms_inc;
    logic [RATE_W-1:0] upd_target;
    logic [RATE_W+2:0] est_x5;
    logic [RATE_W+2:0] cap_x4;

    lbc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    assign adv       = stg_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !stg_valid_reg || adv;

    assign ms_inc     = ms_reg + MS_W'(1);
    assign upd_target = (stg_type_reg == REQ_REMB) ? stg_rate_reg : target_reg;

    lbc_rate_calc u_calc (
        .cfg     (cfg),
        .current (current_reg),
        .target  (upd_target),
        .loss    (loss_reg),
        .overuse (overuse_reg),
        .upd     (upd)
    );

    always_comb
    begin
        current_next = current_reg;
        target_next  = target_reg;
        loss_next    = loss_reg;
        overuse_next = overuse_reg;
        ms_next      = ms_reg;
        changed_next = 1'b0;
        run_upd      = 1'b0;
        case (stg_type_reg)
            REQ_REMB:
            begin
                target_next = stg_rate_reg;
                run_upd     = 1'b1;
            end
            REQ_LOSS:
            begin
                loss_next = stg_loss_reg;
            end
            REQ_TICK:
            begin
                if (ms_inc >= PERIOD_CNT)
                begin
                    ms_next = '0;
                    run_upd = 1'b1;
                end
                else
                begin
                    ms_next = ms_inc;
                end
            end
            REQ_OVERRIDE:
            begin
                current_next = clamp_rate({2'b00, stg_rate_reg}, cfg.min_rate, cfg.max_rate);
            end
            default: ;
        endcase
        if (run_upd)
        begin
            current_next = upd.rate;
            overuse_next = upd.overuse;
            changed_next = upd.changed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            current_reg   <= RST_START;
            target_reg    <= RST_START;
            loss_reg      <= '0;
            overuse_reg   <= 1'b0;
            ms_reg        <= '0;
            changed_reg   <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                stg_valid_reg <= req.valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                changed_reg   <= changed_next;
                loss_reg      <= loss_next;
                overuse_reg   <= overuse_next;
                ms_reg        <= ms_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.load_start)
            begin
                current_reg <= cfg.start_rate;
                target_reg  <= cfg.start_rate;
            end
            else if (adv)
            begin
                current_reg <= current_next;
                target_reg  <= target_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            stg_type_reg <= req.req_type;
            stg_rate_reg <= req.bitrate_value;
            stg_loss_reg <= req.loss_value;
        end
    end

    // state registers double as the result payload
    assign rsp.valid             = out_valid_reg;
    assign rsp.estimated_bitrate = current_reg;
    assign rsp.cap_bitrate       = target_reg;
    assign rsp.loss_level        = loss_reg;
    assign rsp.overuse_active    = overuse_reg;
    assign rsp.bitrate_changed   = changed_reg;

    // estimate * 5 < cap * 4
    assign est_x5 = {1'b0, current_reg, 2'b00} + {3'b000, current_reg};
    assign cap_x4 = {1'b0, target_reg, 2'b00};
    assign rsp.underuse_active = est_x5 < cap_x4;

    `LBC_ASSERT_NEXT(a_update_within_cap, adv && run_upd && !cfg.load_start,
        current_reg <= target_reg, "rate above cap after update")
    `LBC_ASSERT_NEXT(a_loss_keeps_rate,
        adv && (stg_type_reg == REQ_LOSS) && !cfg.load_start,
        current_reg == $past(current_reg), "loss report changed the rate")
    `LBC_ASSERT_IMPL(a_ms_in_period, 1'b1, ms_reg < PERIOD_CNT,
        "tick counter past the update period")
    `LBC_ASSERT_NEXT(a_held_request, stg_valid_reg && !adv,
        stg_valid_reg && $stable(stg_type_reg) && $stable(stg_rate_reg),
        "pending request lost while result stalled")

endmodule

/* bench/lbc_result_checker.sv */
// ----------------------------------------------------------------------------
// lbc_result_checker
// watches the request, result and register channels of the bitrate controller,
// predicts every result from its own copy of the controller state and checks
// each accepted result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module lbc_result_checker
    import lbc_pkg::*;
#(
    parameter int unsigned TICKS_PER_UPDATE = 25
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lbc_req_if                    req,
    lbc_rsp_if                    rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [LBC_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int                    pending_reports,
    output int                    mismatches
);

    // recovery growth is exactly 51/50
    localparam logic [63:0] RECOVERY_NUM = 64'd51;
    localparam logic [63:0] RECOVERY_DEN = 64'd50;

    typedef struct packed {
        logic [RATE_W-1:0] estimate;
        logic [RATE_W-1:0] cap;
        logic [Q16_W-1:0]  loss;
        logic              overusing;
        logic              underusing;
        logic              changed;
    } rate_report_t;

    logic [RATE_W-1:0] cfg_min;
    logic [RATE_W-1:0] cfg_max;
    logic [Q16_W-1:0]  cfg_thr;
    logic [Q16_W-1:0]  cfg_dec;
    logic [Q16_W-1:0]  cfg_inc;
    logic [RATE_W-1:0] rate_now;
    logic [RATE_W-1:0] cap_now;
    logic [Q16_W-1:0]  loss_now;
    logic              overuse_now;
    logic [MS_W-1:0]   ms_ticks;
    rate_report_t      expected_reports[$];

    // lower bound wins when min is above max
    function automatic logic [47:0] bound_rate(input logic [47:0] v);
        if (v < {16'd0, cfg_min})
            return {16'd0, cfg_min};
        if (v > {16'd0, cfg_max})
            return {16'd0, cfg_max};
        return v;
    endfunction

    function automatic logic apply_rate_update();
        logic [63:0] next_rate;
        if (loss_now > cfg_thr)
        begin
            next_rate   = (64'(rate_now) * 64'(cfg_dec)) >> FRAC_BITS;
            overuse_now = 1'b1;
        end
        else if (!overuse_now)
        begin
            next_rate = (64'(rate_now) * 64'(cfg_inc)) >> FRAC_BITS;
        end
        else
        begin
            next_rate = (64'(rate_now) * RECOVERY_NUM) / RECOVERY_DEN;
            if (loss_now < LOSS_CLEAR)
                overuse_now = 1'b0;
        end
        next_rate = {16'd0, bound_rate(next_rate[47:0])};
        if (next_rate > {32'd0, cap_now})
            next_rate = {32'd0, cap_now};
        if (next_rate[RATE_W-1:0] != rate_now)
        begin
            rate_now = next_rate[RATE_W-1:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic rate_report_t predict_rate_report(input logic [1:0]        kind,
                                                         input logic [RATE_W-1:0] rate_in,
                                                         input logic [Q16_W-1:0]  loss_in);
        rate_report_t rep;
        logic         changed;
        logic [47:0]  bounded;
        changed = 1'b0;
        case (kind)
            REQ_REMB:
            begin
                cap_now = rate_in;
                changed = apply_rate_update();
            end
            REQ_LOSS:
                loss_now = loss_in;
            REQ_TICK:
            begin
                ms_ticks = ms_ticks + MS_W'(1);
                if (ms_ticks >= TICKS_PER_UPDATE)
                begin
                    ms_ticks = '0;
                    changed  = apply_rate_update();
                end
            end
            REQ_OVERRIDE:
            begin
                // no cap by the target here
                bounded  = bound_rate({16'd0, rate_in});
                rate_now = bounded[RATE_W-1:0];
            end
            default: ;
        endcase
        rep.estimate   = rate_now;
        rep.cap        = cap_now;
        rep.loss       = loss_now;
        rep.overusing  = overuse_now;
        // estimate below 0.8 of the target
        rep.underusing = (64'(rate_now) * 64'd5) < (64'(cap_now) * 64'd4);
        rep.changed    = changed;
        return rep;
    endfunction

    function automatic void write_register(input logic [REG_IDX_W-1:0] idx,
                                           input logic [31:0]          data);
        case (idx)
            REG_START:
            begin
                rate_now = data;
                cap_now  = data;
            end
            REG_MIN: cfg_min = data;
            REG_MAX: cfg_max = data;
            REG_THR: cfg_thr = data[Q16_W-1:0];
            REG_DEC: cfg_dec = data[Q16_W-1:0];
            REG_INC: cfg_inc = data[Q16_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic note_mismatch(input string             what,
                                 input logic [RATE_W-1:0] got,
                                 input logic [RATE_W-1:0] want);
        $display("%0t lbc check: %s got %0d want %0d", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rate_report_t want;
        rate_report_t fresh;
        if (!rst_n)
        begin
            cfg_min     = RST_MIN;
            cfg_max     = RST_MAX;
            cfg_thr     = RST_THR;
            cfg_dec     = RST_DEC;
            cfg_inc     = RST_INC;
            rate_now    = RST_START;
            cap_now     = RST_START;
            loss_now    = '0;
            overuse_now = 1'b0;
            ms_ticks    = '0;
            mismatches  = 0;
            expected_reports.delete();
            pending_reports <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                write_register(paddr[LBC_ADDR_W-1:2], pwdata);
            if (req.valid && req.ready)
            begin
                fresh = predict_rate_report(req.req_type, req.bitrate_value, req.loss_value);
                expected_reports = {expected_reports, fresh};
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    note_mismatch("result with no request waiting", rsp.estimated_bitrate, '0);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (rsp.estimated_bitrate !== want.estimate)
                        note_mismatch("estimated_bitrate", rsp.estimated_bitrate,
                                      want.estimate);
                    if (rsp.cap_bitrate !== want.cap)
                        note_mismatch("cap_bitrate", rsp.cap_bitrate, want.cap);
                    if (rsp.loss_level !== want.loss)
                        note_mismatch("loss_level", RATE_W'(rsp.loss_level),
                                      RATE_W'(want.loss));
                    if (rsp.overuse_active !== want.overusing)
                        note_mismatch("overuse_active", RATE_W'(rsp.overuse_active),
                                      RATE_W'(want.overusing));
                    if (rsp.underuse_active !== want.underusing)
                        note_mismatch("underuse_active", RATE_W'(rsp.underuse_active),
                                      RATE_W'(want.underusing));
                    if (rsp.bitrate_changed !== want.changed)
                        note_mismatch("bitrate_changed", RATE_W'(rsp.bitrate_changed),
                                      RATE_W'(want.changed));
                end
            end
            pending_reports <= expected_reports.size();
        end
    end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives requests and register writes into the bitrate controller under random
// idling on both channels, with a long result stall, and gives the verdict
// ----------------------------------------------------------------------------
module testbench;
    import lbc_pkg::*;

    localparam int unsigned         TICKS_PER_UPDATE = 25;
    localparam int                  WATCHDOG_LIMIT   = 2000;
    localparam int                  HOLDOFF_AFTER    = 700;
    localparam int                  HOLDOFF_CYCLES   = 300;
    // addresses past the register map
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI    = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [LBC_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    int                    pending_reports;
    int                    mismatches;
    int                    items_sent;
    int                    results_taken;
    int                    stall_cycles;
    bit                    tx_idle_on;
    bit                    rx_idle_on;
    bit                    holdoff_done;
    logic [Q16_W-1:0]      loss_thr_now;

    lbc_req_if req_ch ();
    lbc_rsp_if rsp_ch ();

    loss_based_bitrate_controller_top #(
        .UPDATE_PERIOD_MS (TICKS_PER_UPDATE)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lbc_result_checker #(
        .TICKS_PER_UPDATE (TICKS_PER_UPDATE)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .pending_reports (pending_reports),
        .mismatches      (mismatches)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            4:       return $urandom_range(0, 200);
            default: return $urandom_range(10000, 5000000);
        endcase
    endfunction

    function automatic logic [Q16_W-1:0] pick_loss();
        int near;
        near = int'(loss_thr_now) + int'($urandom_range(0, 6)) - 3;
        if (near < 0)
            near = 0;
        if (near > 65535)
            near = 65535;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return Q16_W'($urandom_range(0, 327));
            2:       return LOSS_CLEAR;
            3, 4:    return Q16_W'(near);
            5, 6:    return Q16_W'($urandom_range(loss_thr_now, 65535));
            7:       return '1;
            default: return Q16_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_req(input logic [1:0]        kind,
                            input logic [RATE_W-1:0] rate,
                            input logic [Q16_W-1:0]  loss);
        int gap;
        if (items_sent % 64 == 0)
            tx_idle_on = ($urandom_range(0, 2) != 0);
        gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.bitrate_value <= rate;
        req_ch.loss_value    <= loss;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    // ignored fields carry noise; now and then a remb cap lands mid-run
    task automatic send_ticks(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 11) == 0)
                push_req(REQ_REMB, pick_rate(), Q16_W'($urandom_range(0, 65535)));
            else
                push_req(REQ_TICK, $urandom, Q16_W'($urandom_range(0, 65535)));
        end
    endtask

    task automatic run_traffic(input int goal);
        int               stop_at;
        logic [Q16_W-1:0] high_loss;
        logic [Q16_W-1:0] mid_loss;
        stop_at = items_sent + goal;
        while (items_sent < stop_at)
        begin
            high_loss = (loss_thr_now == '1) ? '1 :
                        Q16_W'($urandom_range(loss_thr_now + 1, 65535));
            mid_loss  = (loss_thr_now >= LOSS_CLEAR) ?
                        Q16_W'($urandom_range(LOSS_CLEAR, loss_thr_now)) : LOSS_CLEAR;
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    push_req(REQ_LOSS, $urandom, pick_loss());
                    send_ticks($urandom_range(1, 30));
                end
                3, 4:
                begin
                    // congestion, recovery, then clearing
                    push_req(REQ_LOSS, $urandom, high_loss);
                    send_ticks($urandom_range(25, 30));
                    push_req(REQ_LOSS, $urandom, mid_loss);
                    send_ticks($urandom_range(25, 60));
                    push_req(REQ_LOSS, $urandom, Q16_W'($urandom_range(0, LOSS_CLEAR - 1)));
                    send_ticks($urandom_range(25, 30));
                end
                5:
                    repeat ($urandom_range(1, 4))
                        push_req(REQ_REMB, pick_rate(), Q16_W'($urandom_range(0, 65535)));
                6:
                begin
                    push_req(REQ_OVERRIDE, pick_rate(), Q16_W'($urandom_range(0, 65535)));
                    send_ticks($urandom_range(1, 10));
                end
                default:
                    push_req(2'($urandom_range(0, 3)), pick_rate(),
                             Q16_W'($urandom_range(0, 65535)));
            endcase
        end
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_reports != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] start_rate, input logic [31:0] min_rate,
                               input logic [31:0] max_rate, input logic [15:0] thr,
                               input logic [15:0] dec, input logic [15:0] inc);
        write_cfg(REG_MIN, min_rate);
        write_cfg(REG_MAX, max_rate);
        write_cfg(REG_THR, {16'd0, thr});
        write_cfg(REG_DEC, {16'd0, dec});
        write_cfg(REG_INC, {16'd0, inc});
        write_cfg(REG_START, start_rate);
        loss_thr_now = thr;
    endtask

    // result side: random stalls plus one long hold-off so the block backs up
    initial
    begin : result_sink
        int gap;
        results_taken = 0;
        holdoff_done  = 1'b0;
        rx_idle_on    = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!holdoff_done && results_taken >= HOLDOFF_AFTER)
            begin
                holdoff_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            if (results_taken % 64 == 0)
                rx_idle_on = ($urandom_range(0, 2) != 0);
            gap = rx_idle_on ? $urandom_range(0, 16) : 0;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            results_taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[loss_based_bitrate_controller_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_TICK;
        req_ch.bitrate_value <= '0;
        req_ch.loss_value    <= '0;
        items_sent    = 0;
        tx_idle_on    = 1'b0;
        loss_thr_now  = RST_THR;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: caps, clamps, threshold edges, recovery entry and exit
        push_req(REQ_REMB, '1, '0);
        push_req(REQ_REMB, '0, '1);
        push_req(REQ_OVERRIDE, '0, '0);
        push_req(REQ_OVERRIDE, '1, '0);
        push_req(REQ_REMB, 32'd1000000, '0);
        push_req(REQ_LOSS, '1, RST_THR);
        push_req(REQ_REMB, 32'd1000000, '0);
        push_req(REQ_LOSS, '0, RST_THR + 16'd1);
        push_req(REQ_REMB, 32'd2000000, '0);
        push_req(REQ_LOSS, '0, LOSS_CLEAR);
        push_req(REQ_REMB, 32'd2000000, '0);
        push_req(REQ_LOSS, '0, LOSS_CLEAR - 16'd1);
        push_req(REQ_REMB, 32'd2000000, '0);
        push_req(REQ_REMB, 32'd2000000, '0);
        push_req(REQ_LOSS, '0, '1);
        push_req(REQ_REMB, '1, '0);
        push_req(REQ_LOSS, '1, '0);
        push_req(REQ_TICK, '1, '1);
        push_req(REQ_TICK, '0, '0);
        push_req(REQ_TICK, '1, '1);
        push_req(REQ_LOSS, '1, '0);
        run_traffic(480);
        settle();

        // widest bounds, zero threshold, largest factors
        load_config('1, '0, '1, '0, '1, '1);
        write_cfg(REG_SPARE_LO, $urandom);
        write_cfg(REG_SPARE_HI, $urandom);
        run_traffic(300);
        settle();

        // min above max, zero factors, threshold never exceeded
        load_config('0, 32'd1000000, 32'd500000, '1, '0, '0);
        run_traffic(300);
        settle();

        load_config($urandom_range(10000, 5000000), $urandom_range(0, 100000),
                    $urandom_range(1000000, 10000000), Q16_W'($urandom_range(0, 20000)),
                    Q16_W'($urandom_range(8000, 16384)), Q16_W'($urandom_range(16384, 20000)));
        run_traffic(400);
        settle();

        load_config($urandom, $urandom, $urandom, Q16_W'($urandom_range(0, 65535)),
                    Q16_W'($urandom_range(0, 65535)), Q16_W'($urandom_range(0, 65535)));
        run_traffic(400);
        settle();

        if (mismatches == 0)
            $display("[loss_based_bitrate_controller_top] OK");
        else
            $display("[loss_based_bitrate_controller_top] ERROR");
        $finish;
    end

endmodule
